// ----- design/tfp_pkg.sv -----
// ----------------------------------------------------------------------------
// tfp_pkg
// Shared types and constants for the tuning frame parser.
// ----------------------------------------------------------------------------
package tfp_pkg;

    localparam logic [7:0] MARK_HEAD  = 8'hAA;
    localparam logic [7:0] MARK_SYNC  = 8'hFF;
    localparam logic [7:0] TYPE_GAIN  = 8'h02;
    localparam logic [7:0] TYPE_SPEED = 8'h03;

    localparam logic [2:0] LEN_GAIN  = 3'd3;
    localparam logic [2:0] LEN_SPEED = 3'd4;

    localparam logic [3:0] STEP_IDLE    = 4'd0;
    localparam logic [3:0] STEP_HEAD    = 4'd1;
    localparam logic [3:0] STEP_TYPE    = 4'd2;
    localparam logic [3:0] STEP_PAYLOAD = 4'd3;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_GAIN  = 2'd1,
        KIND_SPEED = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MOTION_KEEP    = 2'd0,
        MOTION_STOP    = 2'd1,
        MOTION_FORWARD = 2'd2,
        MOTION_LEFT    = 2'd3
    } motion_t;

    typedef struct packed {
        motion_t     motion_code;
        logic        gains_valid;
        logic [7:0]  gain_p;
        logic [7:0]  gain_i;
        logic [7:0]  gain_d;
        logic        speeds_valid;
        logic [15:0] speed_first;
        logic [15:0] speed_second;
    } result_t;

endpackage

// ----- design/tuning_frame_parser.sv -----
// ----------------------------------------------------------------------------
// tuning_frame_parser
// Byte-serial parser for AA FF type payload FF AA tuning frames.
// ----------------------------------------------------------------------------
// Takes one received byte per beat, one beat every cycle while in_stall is low,
// and gives exactly one registered result beat per byte. The frame state
// updates in the cycle the byte is taken; the result sits in an output register
// backed by one skid entry, so a byte is still taken while a result waits, and
// in_stall rises only when both entries hold results.
module tuning_frame_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  motion_code,
    output logic        gains_valid,
    output logic [7:0]  gain_p,
    output logic [7:0]  gain_i,
    output logic [7:0]  gain_d,
    output logic        speeds_valid,
    output logic [15:0] speed_first,
    output logic [15:0] speed_second
);

    logic             accept;
    logic             buf_full;
    tfp_pkg::result_t step_result;
    tfp_pkg::result_t out_data;

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    tfp_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .result  (step_result)
    );

    tfp_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (step_result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign motion_code  = out_data.motion_code;
    assign gains_valid  = out_data.gains_valid;
    assign gain_p       = out_data.gain_p;
    assign gain_i       = out_data.gain_i;
    assign gain_d       = out_data.gain_d;
    assign speeds_valid = out_data.speeds_valid;
    assign speed_first  = out_data.speed_first;
    assign speed_second = out_data.speed_second;

endmodule

// ----- design/tfp_parser.sv -----
// ----------------------------------------------------------------------------
// tfp_parser
// Frame state and payload store; computes the result of one byte.
// ----------------------------------------------------------------------------
module tfp_parser
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       rx_byte,
    output tfp_pkg::result_t result
);

    logic [3:0]     step_reg;
    logic [3:0]     step_next;
    logic [2:0]     len_reg;
    logic [2:0]     len_next;
    tfp_pkg::kind_t kind_reg;
    tfp_pkg::kind_t kind_next;
    logic [2:0]     index_reg;
    logic [2:0]     index_next;
    logic [7:0]     store_reg [4];
    logic           store_wr;

    logic [3:0]     end_step;
    logic [3:0]     tail_step;
    logic [2:0]     index_inc;

    assign end_step  = tfp_pkg::STEP_PAYLOAD + {1'b0, len_reg};
    assign tail_step = end_step + 4'd1;

    always_comb
    begin
        step_next  = step_reg;
        len_next   = len_reg;
        kind_next  = kind_reg;
        index_next = index_reg;
        index_inc  = index_reg;
        store_wr   = 1'b0;
        result     = '0;
        result.motion_code = tfp_pkg::MOTION_KEEP;

        if (step_reg == tfp_pkg::STEP_IDLE && rx_byte == tfp_pkg::MARK_HEAD)
        begin
            step_next = tfp_pkg::STEP_HEAD;
            result.motion_code = tfp_pkg::MOTION_STOP;
        end
        else if (step_reg == tfp_pkg::STEP_HEAD && rx_byte == tfp_pkg::MARK_SYNC)
        begin
            step_next = tfp_pkg::STEP_TYPE;
        end
        else if (step_reg == tfp_pkg::STEP_TYPE)
        begin
            if (rx_byte == tfp_pkg::TYPE_GAIN)
            begin
                len_next  = tfp_pkg::LEN_GAIN;
                kind_next = tfp_pkg::KIND_GAIN;
                step_next = tfp_pkg::STEP_PAYLOAD;
            end
            else if (rx_byte == tfp_pkg::TYPE_SPEED)
            begin
                len_next  = tfp_pkg::LEN_SPEED;
                kind_next = tfp_pkg::KIND_SPEED;
                step_next = tfp_pkg::STEP_PAYLOAD;
            end
            else
            begin
                step_next = tfp_pkg::STEP_IDLE;
                len_next  = '0;
                kind_next = tfp_pkg::KIND_NONE;
            end
        end
        else if (step_reg >= tfp_pkg::STEP_PAYLOAD && step_reg < end_step)
        begin
            if (index_reg < len_reg)
            begin
                store_wr  = 1'b1;
                step_next = step_reg + 4'd1;
                index_inc = index_reg + 3'd1;
            end
            index_next = (index_inc == len_reg) ? 3'd0 : index_inc;
        end
        else if (step_reg == end_step && rx_byte == tfp_pkg::MARK_SYNC)
        begin
            step_next = step_reg + 4'd1;
        end
        else if (step_reg == tail_step && rx_byte == tfp_pkg::MARK_HEAD)
        begin
            result.motion_code = tfp_pkg::MOTION_LEFT;
            if (kind_reg == tfp_pkg::KIND_GAIN)
            begin
                result.gains_valid = 1'b1;
                result.gain_p      = store_reg[0];
                result.gain_i      = store_reg[1];
                result.gain_d      = store_reg[2];
            end
            else if (kind_reg == tfp_pkg::KIND_SPEED)
            begin
                result.speeds_valid = 1'b1;
                result.speed_first  = {store_reg[1], store_reg[0]};
                result.speed_second = {store_reg[3], store_reg[2]};
            end
            step_next  = tfp_pkg::STEP_IDLE;
            len_next   = '0;
            kind_next  = tfp_pkg::KIND_NONE;
            index_next = '0;
        end
        else
        begin
            result.motion_code = tfp_pkg::MOTION_FORWARD;
            step_next  = tfp_pkg::STEP_IDLE;
            len_next   = '0;
            kind_next  = tfp_pkg::KIND_NONE;
            index_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= tfp_pkg::STEP_IDLE;
            len_reg   <= '0;
            kind_reg  <= tfp_pkg::KIND_NONE;
            index_reg <= '0;
        end
        else if (accept)
        begin
            step_reg  <= step_next;
            len_reg   <= len_next;
            kind_reg  <= kind_next;
            index_reg <= index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && store_wr)
        begin
            store_reg[index_reg[1:0]] <= rx_byte;
        end
    end

endmodule

// ----- design/tfp_out_buf.sv -----
// ----------------------------------------------------------------------------
// tfp_out_buf
// Result register with a skid stage so a beat is taken while the output stalls.
// ----------------------------------------------------------------------------
module tfp_out_buf
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tfp_pkg::result_t push_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output tfp_pkg::result_t out_data
);

    logic             out_valid_reg;
    tfp_pkg::result_t out_data_reg;
    logic             skid_valid_reg;
    tfp_pkg::result_t skid_data_reg;
    logic             pop;

    assign pop       = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
    end

endmodule
